[rtl/tournament_branch_predictor_core_macros.svh]
// Assertion macros for the tournament predictor checker.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TBP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbp assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define TBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbp assertion failed");

`endif

[rtl/tbp_pkg.sv]
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int GHB = 12;  // global history bits
  localparam int PIB = 10;  // pc index bits
  localparam int LHB = 10;  // local history bits

  localparam int CLR_BITS = (GHB >= PIB) ? ((GHB >= LHB) ? GHB : LHB)
                                         : ((PIB >= LHB) ? PIB : LHB);

  localparam logic [1:0] CTR_INIT = 2'd1;  // weakly not taken / weakly local
  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] CTR_MIN  = 2'd0;

  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_UPDATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LPAT,
    ST_EVAL
  } fsm_state_t;

  function automatic logic ctr_high(input logic [1:0] c);
    return c[1];
  endfunction

  function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

[rtl/tbp_ram.sv]
`timescale 1ns / 1ps

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/tournament_branch_predictor_core.sv]
`timescale 1ns / 1ps
// Channel  Ports                                       Direction
// -------  ------------------------------------------  ---------
// in       in_valid in_stall in_action in_pc in_taken  request in
// out      out_valid out_stall out_prediction          result out
//          out_chose_global
//
// One request in flight: accept, local history read, local counter read,
// then evaluate and write back; the dependent local history -> counter
// read keeps these steps serial, and evaluation waits for a free output register.
// After reset a clearing pass over 2^CLR_BITS (4096) addresses sweeps all tables;
// in_stall is held high throughout.
// A stalled result holds the finished request in EVAL; table writes wait with it.

module tournament_branch_predictor_core
  import tbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_pc,
  input  logic        in_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_prediction,
  output logic        out_chose_global
);

  fsm_state_t state_r, state_nxt;
  logic [CLR_BITS-1:0] clr_r, clr_nxt;
  logic [GHB-1:0]      ghist_r, ghist_nxt;

  // latched request
  logic           act_r;
  logic           tkn_r;
  logic [PIB-1:0] pidx_r;

  logic out_valid_r, out_valid_nxt;
  logic out_pred_r, out_sel_r;

  logic in_acc, out_free, fin, do_upd;

  // global + chooser counters share one table: {chooser, global}
  logic           gc_we, gc_re;
  logic [GHB-1:0] gc_waddr;
  logic [3:0]     gc_wdata, gc_rdata;

  logic           lh_we, lh_re;
  logic [PIB-1:0] lh_waddr;
  logic [LHB-1:0] lh_wdata, lh_rdata;

  logic           lc_we, lc_re;
  logic [LHB-1:0] lc_waddr;
  logic [1:0]     lc_wdata, lc_rdata;

  logic gpred, lpred, sel, pred, gok, lok;
  logic [1:0] chs_new;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fin      = (state_r == ST_EVAL) && out_free;
  assign do_upd   = fin && (act_r == ACT_UPDATE);

  // component predictions from the old state
  assign gpred = ctr_high(gc_rdata[1:0]);
  assign sel   = ctr_high(gc_rdata[3:2]);
  assign lpred = ctr_high(lc_rdata);
  assign pred  = sel ? gpred : lpred;
  assign gok   = (gpred == tkn_r);
  assign lok   = (lpred == tkn_r);
  // chooser moves only when exactly one component was right
  assign chs_new = (gok != lok) ? ctr_train(gc_rdata[3:2], gok) : gc_rdata[3:2];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_LPAT;
      ST_LPAT:  state_nxt = ST_EVAL;
      ST_EVAL:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_stall = 1'b1;
    gc_re    = 1'b0;
    lh_re    = 1'b0;
    lc_re    = 1'b0;
    gc_we    = 1'b0;
    lh_we    = 1'b0;
    lc_we    = 1'b0;
    gc_waddr = ghist_r;
    gc_wdata = {chs_new, ctr_train(gc_rdata[1:0], tkn_r)};
    lh_waddr = pidx_r;
    lh_wdata = LHB'({lh_rdata, tkn_r});
    lc_waddr = lh_rdata;
    lc_wdata = ctr_train(lc_rdata, tkn_r);
    case (state_r)
      ST_CLEAR: begin
        gc_we    = 1'b1;
        lh_we    = 1'b1;
        lc_we    = 1'b1;
        gc_waddr = clr_r[GHB-1:0];
        gc_wdata = {CTR_INIT, CTR_INIT};
        lh_waddr = clr_r[PIB-1:0];
        lh_wdata = '0;
        lc_waddr = clr_r[LHB-1:0];
        lc_wdata = CTR_INIT;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        gc_re    = in_acc;
        lh_re    = in_acc;
      end
      ST_LPAT: begin
        lc_re = 1'b1;
      end
      ST_EVAL: begin
        gc_we = do_upd;
        lh_we = do_upd;
        lc_we = do_upd;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    clr_nxt       = (state_r == ST_CLEAR) ? clr_r + 1'b1 : clr_r;
    ghist_nxt     = do_upd ? GHB'({ghist_r, tkn_r}) : ghist_r;
    out_valid_nxt = fin ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ghist_r     <= ghist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      tkn_r  <= in_taken;
      pidx_r <= in_pc[PIB-1:0];
    end
    if (fin) begin
      out_pred_r <= pred;
      out_sel_r  <= sel;
    end
  end

  tbp_ram #(.WIDTH(4), .DEPTH(2 ** GHB)) u_gc_ram (
    .clk   (clk),
    .we    (gc_we),
    .waddr (gc_waddr),
    .wdata (gc_wdata),
    .re    (gc_re),
    .raddr (ghist_r),
    .rdata (gc_rdata)
  );

  tbp_ram #(.WIDTH(LHB), .DEPTH(2 ** PIB)) u_lh_ram (
    .clk   (clk),
    .we    (lh_we),
    .waddr (lh_waddr),
    .wdata (lh_wdata),
    .re    (lh_re),
    .raddr (in_pc[PIB-1:0]),
    .rdata (lh_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(2 ** LHB)) u_lc_ram (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .re    (lc_re),
    .raddr (lh_rdata),
    .rdata (lc_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_prediction   = out_pred_r;
  assign out_chose_global = out_sel_r;

endmodule

[rtl/tbp_checker.sv]
`timescale 1ns / 1ps
`include "tournament_branch_predictor_core_macros.svh"

module tbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_prediction,
  input logic        out_chose_global
);

  // a stalled result holds
  `TBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_prediction) && $stable(out_chose_global))

  // one transaction in flight: in_stall stays high through the counter read and evaluation after an accept
  `TBP_ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall ##1 in_stall)

  // a new result only comes out of evaluation, never straight from idle
  `TBP_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (.*);
